>>> sv/cra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_pkg
// shared types and constants for the cpu residency accounting block
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int MAX_FREQS  = 16;
    localparam int MAX_STATES = 8;
    localparam int FW = $clog2(MAX_FREQS);
    localparam int SW = $clog2(MAX_STATES);

    typedef enum logic [2:0] {
        OP_FREQ   = 3'd0,
        OP_ENTER  = 3'd1,
        OP_EXIT   = 3'd2,
        OP_ONLINE = 3'd3,
        OP_OFF    = 3'd4,
        OP_SYNC   = 3'd5,
        OP_READ   = 3'd6,
        OP_CLEAR  = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        K_BUSY  = 3'd0,
        K_IDLE  = 3'd1,
        K_OFF   = 3'd2,
        K_RES   = 3'd3,
        K_STATE = 3'd4,
        K_GBUSY = 3'd5,
        K_GIDLE = 3'd6,
        K_GOFF  = 3'd7
    } t_kind;

    localparam logic [1:0] MODE_RUN  = 2'd0;
    localparam logic [1:0] MODE_IDLE = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    localparam logic REG_NFREQ  = 1'b0;
    localparam logic REG_NSTATE = 1'b1;

    // datapath commands
    typedef enum logic [3:0] {
        C_NONE,
        C_CHARGE,   // charge span by mode, set new mode / freq
        C_EXIT,     // charge final span to idle totals of exit state
        C_FOLD,     // move one pending entry into residency
        C_CLEAR,    // clear one row of each store, all written marks and the global totals
        C_READ      // register read value
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] new_mode;
        logic       set_mode;
        logic       set_freq;
        logic       set_ts;
    } t_ctl;

endpackage

>>> sv/cra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_datapath
// counter stores, span charging, pending fold and read selection
// ----------------------------------------------------------------------------
module cra_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cra_pkg::t_ctl          i_ctl,
    input  logic [cra_pkg::FW-1:0] i_idx,      // fold / clear row
    input  logic [cra_pkg::SW-1:0] i_state,    // exit state, clamped
    input  logic [cra_pkg::FW-1:0] i_freq,     // clamped new freq
    input  logic [cra_pkg::FW:0]   i_fc,       // effective freq count
    input  logic [63:0]            i_ts,
    input  logic [3:0]             i_rd_freq,
    input  logic [2:0]             i_rd_state,
    input  logic [2:0]             i_kind,
    input  logic                   i_rd_fok,
    input  logic                   i_rd_sok,
    output logic [1:0]             o_mode,
    output logic [63:0]            o_rd
);
    import cra_pkg::*;

    localparam int RDEPTH = MAX_FREQS * MAX_STATES;
    localparam int RW = FW + SW;

    logic [63:0] r_res [RDEPTH];
    logic [RDEPTH-1:0] r_res_ok;
    logic [63:0] r_idle [MAX_FREQS];
    logic [63:0] r_busy [MAX_FREQS];
    logic [63:0] r_off  [MAX_FREQS];
    logic [63:0] r_pend [MAX_FREQS];
    logic [63:0] r_stot [MAX_STATES];
    logic [63:0] r_gbusy, r_gidle, r_goff, r_last;
    logic [FW-1:0] r_cur;
    logic [1:0]    r_mode;
    logic [63:0]   r_rd;
    logic          r_rd_res;
    logic [63:0]   r_rq;
    logic          r_rqok;
    logic [63:0]   r_fadd;
    logic [RW-1:0] r_fa;
    logic          r_fwr;
    logic [63:0]   r_dx;

    logic [FW-1:0] w_f;
    logic [63:0]   w_d;
    logic [63:0]   w_pend;
    logic [RW-1:0] w_ra;
    logic [FW-1:0] w_rf;
    logic [SW-1:0] w_rs;
    logic          w_rmem;
    logic [63:0]   w_rq;

    assign w_f  = ({1'b0, r_cur} >= i_fc) ? FW'(i_fc - 1'b1) : r_cur;
    assign w_d  = i_ts - r_last;
    assign w_pend = r_pend[i_idx];
    assign w_rf = i_rd_freq[FW-1:0];
    assign w_rs = i_rd_state[SW-1:0];
    assign w_ra = (i_ctl.cmd == C_READ) ? {w_rf, w_rs} : {i_idx, i_state};
    assign w_rmem = (i_ctl.cmd == C_READ) || (i_ctl.cmd == C_FOLD);
    assign w_rq = r_rqok ? r_rq : '0;

    // residency store: registered read, with the fold sum written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (r_fwr) r_res[r_fa] <= w_rq + r_fadd;
        if (w_rmem) r_rq <= r_res[w_ra];
    end

    // written marks, cleared together so unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == C_CLEAR) begin
            r_res_ok <= '0;
        end else if (r_fwr) begin
            r_res_ok[r_fa] <= 1'b1;
        end
        if (w_rmem) r_rqok <= r_res_ok[w_ra];
    end

    // the final span of an idle exit joins the fold of its own row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwr <= 1'b0;
        end else begin
            r_fwr <= (i_ctl.cmd == C_FOLD);
        end
        if (i_ctl.cmd == C_FOLD) begin
            r_fadd <= w_pend + ((i_idx == w_f) ? r_dx : 64'd0);
            r_fa   <= {i_idx, i_state};
        end
        if (i_ctl.cmd == C_EXIT) r_dx <= w_d;
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            C_CHARGE: begin
                if (r_mode == MODE_IDLE) begin
                    r_pend[w_f] <= r_pend[w_f] + w_d;
                end else if (r_mode >= MODE_OFF) begin
                    r_off[w_f]  <= r_off[w_f] + w_d;
                    r_idle[w_f] <= r_idle[w_f] + w_d;
                    r_goff      <= r_goff + w_d;
                    r_gidle     <= r_gidle + w_d;
                end else begin
                    r_busy[w_f] <= r_busy[w_f] + w_d;
                    r_gbusy     <= r_gbusy + w_d;
                end
            end
            C_EXIT: begin
                r_idle[w_f]     <= r_idle[w_f] + w_d;
                r_stot[i_state] <= r_stot[i_state] + w_d;
                r_gidle         <= r_gidle + w_d;
            end
            C_FOLD: begin
                r_idle[i_idx]   <= r_idle[i_idx] + w_pend;
                r_stot[i_state] <= r_stot[i_state] + w_pend;
                r_gidle         <= r_gidle + w_pend;
                r_pend[i_idx]   <= '0;
            end
            C_CLEAR: begin
                r_idle[i_idx] <= '0;
                r_busy[i_idx] <= '0;
                r_off[i_idx]  <= '0;
                r_pend[i_idx] <= '0;
                if (i_idx < FW'(MAX_STATES)) begin
                    r_stot[i_idx[SW-1:0]] <= '0;
                end
                r_gbusy <= '0;
                r_gidle <= '0;
                r_goff  <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == C_READ) begin
            r_rd_res <= (t_kind'(i_kind) == K_RES) && i_rd_fok && i_rd_sok;
            case (t_kind'(i_kind))
                K_BUSY:  r_rd <= i_rd_fok ? r_busy[w_rf] : '0;
                K_IDLE:  r_rd <= i_rd_fok ? r_idle[w_rf] : '0;
                K_OFF:   r_rd <= i_rd_fok ? r_off[w_rf] : '0;
                K_RES:   r_rd <= '0;
                K_STATE: r_rd <= i_rd_sok ? r_stot[w_rs] : '0;
                K_GBUSY: r_rd <= r_gbusy;
                K_GIDLE: r_rd <= r_gidle;
                default: r_rd <= r_goff;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_cur  <= '0;
            r_mode <= MODE_RUN;
        end else begin
            if (i_ctl.set_ts)   r_last <= i_ts;
            if (i_ctl.set_freq) r_cur  <= i_freq;
            if (i_ctl.set_mode) r_mode <= i_ctl.new_mode;
        end
    end

    assign o_mode = r_mode;
    assign o_rd   = r_rd_res ? w_rq : r_rd;

endmodule

>>> sv/cra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_ctrl
// event sequencer: clear sweep, charge, idle exit fold walk, read output
// ----------------------------------------------------------------------------
module cra_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [2:0]             i_op,
    input  logic [1:0]             i_mode,
    input  logic [cra_pkg::FW:0]   i_fc,
    output logic                   o_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output cra_pkg::t_ctl          o_ctl,
    output logic [cra_pkg::FW-1:0] o_idx,
    output logic                   o_load
);
    import cra_pkg::*;

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_FOLD, S_CLEAR, S_READ, S_OUT} t_state;

    localparam int SWEEP = (MAX_FREQS > MAX_STATES) ? MAX_FREQS : MAX_STATES;
    localparam int XW = $clog2(SWEEP + 1);

    t_state        r_state;
    logic [XW-1:0] r_cnt;
    logic          w_acc;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign o_load  = w_acc;
    assign o_out_valid = (r_state == S_OUT);
    assign o_idx = r_cnt[FW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_INIT, S_CLEAR: begin
                    if (r_cnt == XW'(SWEEP - 1)) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_cnt <= '0;
                        case (t_opcode'(i_op))
                            OP_CLEAR: r_state <= S_CLEAR;
                            OP_READ:  r_state <= S_READ;
                            OP_EXIT:  if (i_mode < MODE_OFF) r_state <= S_FOLD;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FOLD: begin
                    if ({1'b0, r_cnt} + 1'b1 >= (XW+1)'(i_fc)) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_READ: r_state <= S_OUT;
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_ctl = '{cmd: C_NONE, new_mode: MODE_RUN, set_mode: 1'b0,
                  set_freq: 1'b0, set_ts: 1'b0};
        case (r_state)
            S_INIT, S_CLEAR: o_ctl.cmd = C_CLEAR;
            S_FOLD: o_ctl.cmd = C_FOLD;
            S_READ: o_ctl.cmd = C_READ;
            S_IDLE: begin
                if (w_acc) begin
                    o_ctl.set_ts = 1'b1;
                    case (t_opcode'(i_op))
                        OP_FREQ: begin
                            o_ctl.cmd = C_CHARGE;
                            o_ctl.set_freq = 1'b1;
                        end
                        OP_ENTER: begin
                            if (i_mode < MODE_OFF) begin
                                o_ctl.cmd = C_CHARGE;
                                o_ctl.set_mode = 1'b1;
                                o_ctl.new_mode = MODE_IDLE;
                            end else begin
                                o_ctl.set_ts = 1'b0;
                            end
                        end
                        OP_EXIT: begin
                            if (i_mode < MODE_OFF) begin
                                o_ctl.cmd = C_EXIT;
                                o_ctl.set_mode = 1'b1;
                                o_ctl.new_mode = MODE_RUN;
                            end else begin
                                o_ctl.set_ts = 1'b0;
                            end
                        end
                        OP_ONLINE: begin
                            o_ctl.cmd = C_CHARGE;
                            o_ctl.set_mode = 1'b1;
                            o_ctl.new_mode = MODE_RUN;
                        end
                        OP_OFF: begin
                            o_ctl.cmd = C_CHARGE;
                            o_ctl.set_mode = 1'b1;
                            o_ctl.new_mode = MODE_OFF;
                        end
                        OP_CLEAR: o_ctl.cmd = C_NONE;
                        default:  o_ctl.cmd = C_CHARGE;
                    endcase
                end
            end
            default: ;
        endcase
    end

    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_out_valid) else $error("ready while result pending");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    ap_fold_from_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_FOLD) |-> $past(i_op) == OP_EXIT)
        else $error("fold without idle exit");

endmodule

>>> sv/cpu_residency_accounting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_residency_accounting
// per-cpu busy, idle, offline and idle state residency accounting
// ----------------------------------------------------------------------------
// Each event but clear, and enter or exit while offline, charges the time since
// the previous event in the cycle it is accepted, and the input is ready again on
// the next cycle, except: idle exit then walks the pending store one row per
// cycle over the rows of the frequency count in use; read selects the counter in
// the cycle after the accept and holds the result until the output handshake;
// clear sweeps the rows of the stores after the accept. After reset the same
// sweep runs before the first item is accepted.
module cpu_residency_accounting (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], timestamp[66:3], freq_level[70:67], idle_level[73:71],
    // counter_kind[76:74], zero fill to 80
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // counter_value[63:0]
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    import cra_pkg::*;

    logic [4:0] r_fcnt;
    logic [3:0] r_scnt;
    logic [FW:0] w_fc;
    logic [SW:0] w_sc;
    logic [2:0]  w_op;
    logic [63:0] w_tsin;
    logic [3:0]  w_fl;
    logic [2:0]  w_il, w_kind;
    logic [63:0] r_ts;
    logic [3:0]  r_fl;
    logic [2:0]  r_il, r_kind;
    logic [SW-1:0] r_st;
    logic [FW-1:0] w_fcl;
    logic [SW-1:0] w_scl;
    t_ctl        w_ctl;
    logic [FW-1:0] w_idx;
    logic [1:0]  w_mode;
    logic        w_load;
    logic [63:0] w_ts_dp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= 5'(MAX_FREQS);
            r_scnt <= 4'(MAX_STATES);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NFREQ) r_fcnt <= i_cfg_data;
            else                        r_scnt <= i_cfg_data[3:0];
        end
    end

    assign w_fc = (r_fcnt == '0) ? (FW+1)'(1)
                : (32'(r_fcnt) > MAX_FREQS) ? (FW+1)'(MAX_FREQS) : (FW+1)'(r_fcnt);
    assign w_sc = (r_scnt == '0) ? (SW+1)'(1)
                : (32'(r_scnt) > MAX_STATES) ? (SW+1)'(MAX_STATES) : (SW+1)'(r_scnt);

    assign w_op   = s_axis_tdata[2:0];
    assign w_tsin = s_axis_tdata[66:3];
    assign w_fl   = s_axis_tdata[70:67];
    assign w_il   = s_axis_tdata[73:71];
    assign w_kind = s_axis_tdata[76:74];

    assign w_fcl = (32'(w_fl) >= 32'(w_fc)) ? FW'(w_fc - 1'b1) : FW'(w_fl);
    assign w_scl = (32'(w_il) >= 32'(w_sc)) ? SW'(w_sc - 1'b1) : SW'(w_il);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ts   <= w_tsin;
            r_fl   <= w_fl;
            r_il   <= w_il;
            r_kind <= w_kind;
            r_st   <= w_scl;
        end
    end

    // the charge and exit run in the accept cycle; folds and reads use held fields
    assign w_ts_dp = w_load ? w_tsin : r_ts;

    cra_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .i_op(w_op), .i_mode(w_mode), .i_fc(w_fc),
        .o_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .o_ctl(w_ctl), .o_idx(w_idx), .o_load(w_load)
    );

    cra_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_idx(w_idx),
        .i_state(w_load ? w_scl : r_st), .i_freq(w_fcl), .i_fc(w_fc),
        .i_ts(w_ts_dp),
        .i_rd_freq(w_load ? w_fl : r_fl), .i_rd_state(w_load ? w_il : r_il),
        .i_kind(w_load ? w_kind : r_kind),
        .i_rd_fok(32'(w_load ? w_fl : r_fl) < 32'(w_fc)),
        .i_rd_sok(32'(w_load ? w_il : r_il) < 32'(w_sc)),
        .o_mode(w_mode), .o_rd(m_axis_tdata)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking test of cpu_residency_accounting: a local accounting model
// predicts every read value from the accepted event items, with random gaps
// on both streams, several count settings and directed corner events
// ----------------------------------------------------------------------------
module testbench;
    import cra_pkg::*;

    localparam int NF = MAX_FREQS;
    localparam int NS = MAX_STATES;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [4:0]  i_cfg_data = '0;

    cpu_residency_accounting u_top (.*);

    always #2 i_clk = ~i_clk;

    // accounting model state
    logic [63:0] acct_res [NF][NS];
    logic [63:0] acct_idle [NF];
    logic [63:0] acct_busy [NF];
    logic [63:0] acct_off [NF];
    logic [63:0] acct_pend [NF];
    logic [63:0] acct_stot [NS];
    logic [63:0] acct_gbusy, acct_gidle, acct_goff, acct_last_ts;
    int          acct_freq;
    logic [1:0]  acct_mode;
    logic [4:0]  tb_nfreq;
    logic [3:0]  tb_nstate;

    logic [63:0] expected_counts [$];
    int          n_err = 0;
    int          idle_cycles = 0;
    bit          rx_stalls = 1'b1;
    bit          tx_gaps = 1'b1;
    logic [63:0] cur_ts = '0;

    function automatic int eff_count(int v, int mx);
        if (v == 0) return 1;
        return (v > mx) ? mx : v;
    endfunction

    function automatic int clamp(int v, int cnt);
        return (v >= cnt) ? cnt - 1 : v;
    endfunction

    task automatic acct_clear(logic [63:0] ts);
        for (int f = 0; f < NF; f++) begin
            for (int s = 0; s < NS; s++) acct_res[f][s] = '0;
            acct_idle[f] = '0;
            acct_busy[f] = '0;
            acct_off[f] = '0;
            acct_pend[f] = '0;
        end
        for (int s = 0; s < NS; s++) acct_stot[s] = '0;
        acct_gbusy = '0;
        acct_gidle = '0;
        acct_goff = '0;
        acct_last_ts = ts;
    endtask

    task automatic acct_charge(logic [63:0] ts, bit exiting, int s);
        int fc;
        int f;
        logic [63:0] d;
        logic [63:0] p;
        fc = eff_count(tb_nfreq, NF);
        f = clamp(acct_freq, fc);
        d = ts - acct_last_ts;
        if (acct_mode == MODE_IDLE && !exiting) begin
            acct_pend[f] += d;
        end else if (acct_mode >= MODE_OFF) begin
            acct_off[f] += d;
            acct_idle[f] += d;
            acct_goff += d;
            acct_gidle += d;
        end else if (exiting) begin
            acct_res[f][s] += d;
            acct_idle[f] += d;
            acct_stot[s] += d;
            acct_gidle += d;
            for (int i = 0; i < fc; i++) begin
                p = acct_pend[i];
                acct_res[i][s] += p;
                acct_idle[i] += p;
                acct_stot[s] += p;
                acct_gidle += p;
                acct_pend[i] = '0;
            end
        end else begin
            acct_busy[f] += d;
            acct_gbusy += d;
        end
        acct_last_ts = ts;
    endtask

    task automatic acct_event(t_opcode op, logic [63:0] ts, int fl, int il, t_kind kind);
        int fc;
        int sc;
        logic [63:0] v;
        fc = eff_count(tb_nfreq, NF);
        sc = eff_count(tb_nstate, NS);
        v = '0;
        case (op)
            OP_FREQ: begin
                acct_charge(ts, 0, 0);
                acct_freq = clamp(fl, fc);
            end
            OP_ENTER: begin
                if (acct_mode < MODE_OFF) begin
                    acct_charge(ts, 0, 0);
                    acct_mode = MODE_IDLE;
                end
            end
            OP_EXIT: begin
                if (acct_mode < MODE_OFF) begin
                    acct_mode = MODE_RUN;
                    acct_charge(ts, 1, clamp(il, sc));
                end
            end
            OP_ONLINE: begin
                acct_charge(ts, 0, 0);
                acct_mode = MODE_RUN;
            end
            OP_OFF: begin
                acct_charge(ts, 0, 0);
                acct_mode = MODE_OFF;
            end
            OP_SYNC: acct_charge(ts, 0, 0);
            OP_CLEAR: acct_clear(ts);
            default: begin
                acct_charge(ts, 0, 0);
                case (kind)
                    K_BUSY:  if (fl < fc) v = acct_busy[fl];
                    K_IDLE:  if (fl < fc) v = acct_idle[fl];
                    K_OFF:   if (fl < fc) v = acct_off[fl];
                    K_RES:   if (fl < fc && il < sc) v = acct_res[fl][il];
                    K_STATE: if (il < sc) v = acct_stot[il];
                    K_GBUSY: v = acct_gbusy;
                    K_GIDLE: v = acct_gidle;
                    default: v = acct_goff;
                endcase
                expected_counts.push_back(v);
            end
        endcase
    endtask

    function automatic int rand_gap();
        if (!tx_gaps || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_event(t_opcode op, logic [63:0] ts, int fl, int il, t_kind kind);
        int gap;
        gap = rand_gap();
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, 3'(kind), 3'(il), 4'(fl), ts, 3'(op)};
        do @(posedge i_clk); while (!s_axis_tready);
        acct_event(op, ts, fl, il, kind);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (NF + NS + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_NFREQ) tb_nfreq = data;
        else tb_nstate = data[3:0];
        @(posedge i_clk);
    endtask

    task automatic set_counts(logic [4:0] fc, logic [4:0] sc);
        wait_drained();
        write_reg(REG_NFREQ, fc);
        write_reg(REG_NSTATE, sc);
    endtask

    function automatic logic [63:0] next_ts();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) cur_ts = cur_ts + $urandom_range(0, 5000);
        else if (r < 93) cur_ts = cur_ts + {$urandom(), $urandom()};
        else cur_ts = {$urandom(), $urandom()};
        return cur_ts;
    endfunction

    task automatic read_all_kinds(int fl, int il);
        for (int k = 0; k < 8; k++) send_event(OP_READ, next_ts(), fl, il, t_kind'(k));
    endtask

    task automatic test_directed();
        send_event(OP_SYNC, 64'd0, 0, 0, K_BUSY);
        send_event(OP_FREQ, 64'd100, 15, 0, K_BUSY);
        send_event(OP_ENTER, 64'd300, 0, 0, K_BUSY);
        send_event(OP_FREQ, 64'd350, 3, 0, K_BUSY);
        send_event(OP_EXIT, 64'd500, 0, 7, K_BUSY);
        send_event(OP_EXIT, 64'd900, 0, 2, K_BUSY);
        send_event(OP_OFF, 64'd1000, 0, 0, K_BUSY);
        send_event(OP_ENTER, 64'd1100, 0, 0, K_BUSY);
        send_event(OP_EXIT, 64'd1200, 0, 1, K_BUSY);
        send_event(OP_ONLINE, 64'd1500, 0, 0, K_BUSY);
        send_event(OP_SYNC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, K_BUSY);
        send_event(OP_SYNC, 64'd40, 0, 0, K_BUSY);
        cur_ts = 64'd40;
        read_all_kinds(3, 7);
        read_all_kinds(15, 2);
        send_event(OP_CLEAR, 64'd2000, 0, 0, K_BUSY);
        send_event(OP_READ, 64'd2500, 3, 7, K_BUSY);
        send_event(OP_READ, 64'd2600, 0, 0, K_GBUSY);
        cur_ts = 64'd2600;
    endtask

    task automatic test_count_clamp();
        set_counts(5'd3, 5'd2);
        send_event(OP_FREQ, next_ts(), 9, 0, K_BUSY);
        send_event(OP_ENTER, next_ts(), 0, 0, K_BUSY);
        send_event(OP_EXIT, next_ts(), 0, 6, K_BUSY);
        read_all_kinds(2, 1);
        read_all_kinds(3, 2);
    endtask

    task automatic test_shrink_pending();
        set_counts(5'd16, 5'd8);
        send_event(OP_FREQ, next_ts(), 12, 0, K_BUSY);
        send_event(OP_ENTER, next_ts(), 0, 0, K_BUSY);
        send_event(OP_FREQ, next_ts(), 1, 0, K_BUSY);
        send_event(OP_SYNC, next_ts(), 0, 0, K_BUSY);
        set_counts(5'd4, 5'd8);
        send_event(OP_EXIT, next_ts(), 0, 3, K_BUSY);
        send_event(OP_READ, next_ts(), 1, 3, K_RES);
        set_counts(5'd16, 5'd8);
        send_event(OP_ENTER, next_ts(), 0, 0, K_BUSY);
        send_event(OP_EXIT, next_ts(), 0, 4, K_BUSY);
        send_event(OP_READ, next_ts(), 12, 4, K_RES);
        send_event(OP_READ, next_ts(), 0, 4, K_STATE);
    endtask

    function automatic t_opcode rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return OP_FREQ;
        if (r < 32) return OP_ENTER;
        if (r < 48) return OP_EXIT;
        if (r < 55) return OP_ONLINE;
        if (r < 60) return OP_OFF;
        if (r < 67) return OP_SYNC;
        if (r < 69) return OP_CLEAR;
        return OP_READ;
    endfunction

    task automatic test_random(logic [4:0] fc, logic [4:0] sc, int n);
        set_counts(fc, sc);
        tx_gaps = $urandom_range(0, 3) != 0;
        rx_stalls = $urandom_range(0, 3) != 0;
        for (int i = 0; i < n; i++) begin
            send_event(rand_op(), next_ts(), $urandom_range(0, 15), $urandom_range(0, 7),
                       t_kind'($urandom_range(0, 7)));
        end
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // receiver: random stall stretches
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!rx_stalls) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            m_axis_tready <= 1'b1;
        end else begin
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                     : $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected item counter_value actual %h", m_axis_tdata);
                n_err++;
            end else begin
                if (m_axis_tdata !== expected_counts[0]) begin
                    $error("counter_value expected %h actual %h", expected_counts[0],
                           m_axis_tdata);
                    n_err++;
                end
                void'(expected_counts.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[cpu_residency_accounting] ERROR");
            $finish;
        end
    end

    initial begin
        tb_nfreq = 5'd16;
        tb_nstate = 4'd8;
        acct_freq = 0;
        acct_mode = MODE_RUN;
        acct_clear(64'd0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_count_clamp();
        test_shrink_pending();
        test_random(5'd16, 5'd8, 230);
        test_random(5'd1, 5'd1, 200);
        test_random(5'd0, 5'd0, 120);
        test_random(5'd31, 5'd31, 220);
        test_random(5'd17, 5'd9, 120);
        test_random(5'd5, 5'd3, 220);
        test_random(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 220);
        wait_drained();
        if (n_err == 0 && expected_counts.size() == 0)
            $display("[cpu_residency_accounting] OK");
        else
            $display("[cpu_residency_accounting] ERROR");
        $finish;
    end

endmodule

>>> cpu_residency_accounting.f
sv/cra_pkg.sv
sv/cra_datapath.sv
sv/cra_ctrl.sv
sv/cpu_residency_accounting.sv
test/testbench.sv
